[sv/bcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcw_pkg
// Shared types and constants for the bounded channel with parked requesters.
// ----------------------------------------------------------------------------
package bcw_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = QW + 1;
    localparam int ID_W        = 4;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int PARK_LIMIT  = 15;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND      = 3'd0,
        CMD_TRY_SEND  = 3'd1,
        CMD_RECV      = 3'd2,
        CMD_TRY_RECV  = 3'd3,
        CMD_CLOSE     = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BLOCK  = 2'd1,
        ST_CLOSED = 2'd2,
        ST_ERROR  = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        TSEL_CALLER,
        TSEL_RECV,
        TSEL_SEND
    } tsel_t;

    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_IN,
        DSEL_RING,
        DSEL_GOT
    } dsel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_OUT_A,
        S_OUT_B,
        S_CL_POP,
        S_CL_OUT
    } state_t;

    typedef struct packed {
        tsel_t   tsel;
        status_e status;
        dsel_t   dsel;
        logic    last;
    } res_t;

    typedef struct packed {
        logic capture_in;
        logic out_load;
        logic out_from_pend;
        logic pend_load;
        res_t out_res;
        res_t pend_res;
        logic ring_push;
        logic ring_pop;
        logic ring_swap;
        logic rq_push;
        logic rq_pop;
        logic sq_push;
        logic sq_pop;
        logic set_closed;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic closed;
        logic rq_nonempty;
        logic sq_nonempty;
        logic fill_zero;
        logic has_room;
        logic can_park_r;
        logic can_park_s;
    } dp_stat_t;

endpackage
`default_nettype wire

[sv/bcw_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcw_datapath
// Ring buffer, wait queues, counters and result registers.
// ----------------------------------------------------------------------------
module bcw_datapath (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [4:0]              cfg_wr_data,
    input  wire logic [bcw_pkg::CMD_W-1:0]  in_cmd,
    input  wire logic [bcw_pkg::ID_W-1:0]   in_who,
    input  wire logic [bcw_pkg::DATA_W-1:0] in_data,
    input  wire bcw_pkg::dp_cmd_t        dcmd,
    output bcw_pkg::dp_stat_t            dstat,
    output logic [bcw_pkg::ID_W-1:0]     out_target,
    output logic [1:0]                   out_status,
    output logic [bcw_pkg::DATA_W-1:0]   out_data,
    output logic                         out_last
);
    import bcw_pkg::*;

    logic [4:0]        cap_reg;
    logic [CW-1:0]     eff_cap;
    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   who_reg;
    logic [DATA_W-1:0] data_reg;

    logic [DATA_W-1:0]      ring_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]        rq_mem   [QUEUE_DEPTH];
    logic [ID_W+DATA_W-1:0] sq_mem   [QUEUE_DEPTH];
    logic [DATA_W-1:0]      ring_rd_reg;
    logic [ID_W-1:0]        rq_rd_reg;
    logic [ID_W+DATA_W-1:0] sq_rd_reg;

    logic [QW-1:0] wslot_reg, rslot_reg, rhead_reg, rtail_reg, shead_reg, stail_reg;
    logic [CW-1:0] fill_reg, rcount_reg, scount_reg;
    logic          closed_reg;
    logic [CW:0]   wait_sum;

    logic [ID_W-1:0]   tgt_reg, ptgt_reg;
    logic [1:0]        st_reg, pst_reg;
    logic [DATA_W-1:0] od_reg, pd_reg;
    logic              last_reg, plast_reg;
    logic [DATA_W-1:0] got;

    function automatic logic [QW-1:0] advance(input logic [QW-1:0] s, input logic [CW-1:0] c);
        logic [CW-1:0] n;
        n = {1'b0, s} + CW'(1);
        return (n >= c) ? '0 : n[QW-1:0];
    endfunction

    assign eff_cap  = (cap_reg > 5'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(cap_reg);
    assign wait_sum = {1'b0, rcount_reg} + {1'b0, scount_reg};
    assign got      = (fill_reg == '0) ? sq_rd_reg[DATA_W-1:0] : ring_rd_reg;

    always_comb begin
        dstat.cmd         = cmd_reg;
        dstat.closed      = closed_reg;
        dstat.rq_nonempty = rcount_reg != '0;
        dstat.sq_nonempty = scount_reg != '0;
        dstat.fill_zero   = fill_reg == '0;
        dstat.has_room    = fill_reg < eff_cap;
        dstat.can_park_r  = (rcount_reg < CW'(QUEUE_DEPTH)) && (wait_sum < (CW+1)'(PARK_LIMIT));
        dstat.can_park_s  = (scount_reg < CW'(QUEUE_DEPTH)) && (wait_sum < (CW+1)'(PARK_LIMIT));
    end

    function automatic logic [ID_W-1:0] pick_t(input tsel_t t, input logic [ID_W-1:0] w,
                                               input logic [ID_W-1:0] r,
                                               input logic [ID_W-1:0] s);
        case (t)
            TSEL_RECV: return r;
            TSEL_SEND: return s;
            default:   return w;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_d(input dsel_t d, input logic [DATA_W-1:0] i,
                                                 input logic [DATA_W-1:0] rg,
                                                 input logic [DATA_W-1:0] g);
        case (d)
            DSEL_IN:   return i;
            DSEL_RING: return rg;
            DSEL_GOT:  return g;
            default:   return '0;
        endcase
    endfunction

    // memories: registered reads, single write port each
    always_ff @(posedge aclk) begin
        ring_rd_reg <= ring_mem[rslot_reg];
        rq_rd_reg   <= rq_mem[rhead_reg];
        sq_rd_reg   <= sq_mem[shead_reg];
        if (dcmd.ring_push) begin
            ring_mem[wslot_reg] <= data_reg;
        end else if (dcmd.ring_swap && fill_reg != '0) begin
            ring_mem[rslot_reg] <= sq_rd_reg[DATA_W-1:0];
        end
        if (dcmd.rq_push) begin
            rq_mem[rtail_reg] <= who_reg;
        end
        if (dcmd.sq_push) begin
            sq_mem[stail_reg] <= {who_reg, data_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (dcmd.capture_in) begin
            cmd_reg  <= in_cmd;
            who_reg  <= in_who;
            data_reg <= in_data;
        end
        if (dcmd.out_load) begin
            if (dcmd.out_from_pend) begin
                tgt_reg  <= ptgt_reg;
                st_reg   <= pst_reg;
                od_reg   <= pd_reg;
                last_reg <= plast_reg;
            end else begin
                tgt_reg  <= pick_t(dcmd.out_res.tsel, who_reg, rq_rd_reg,
                                   sq_rd_reg[ID_W+DATA_W-1:DATA_W]);
                st_reg   <= dcmd.out_res.status;
                od_reg   <= pick_d(dcmd.out_res.dsel, data_reg, ring_rd_reg, got);
                last_reg <= dcmd.out_res.last;
            end
        end
        if (dcmd.pend_load) begin
            ptgt_reg  <= pick_t(dcmd.pend_res.tsel, who_reg, rq_rd_reg,
                                sq_rd_reg[ID_W+DATA_W-1:DATA_W]);
            pst_reg   <= dcmd.pend_res.status;
            pd_reg    <= pick_d(dcmd.pend_res.dsel, data_reg, ring_rd_reg, got);
            plast_reg <= dcmd.pend_res.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= 5'd16;
            wslot_reg  <= '0;
            rslot_reg  <= '0;
            fill_reg   <= '0;
            closed_reg <= 1'b0;
            rhead_reg  <= '0;
            rtail_reg  <= '0;
            shead_reg  <= '0;
            stail_reg  <= '0;
            rcount_reg <= '0;
            scount_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (dcmd.set_closed) begin
                closed_reg <= 1'b1;
            end
            if (dcmd.ring_push) begin
                wslot_reg <= advance(wslot_reg, eff_cap);
                fill_reg  <= fill_reg + CW'(1);
            end else if (dcmd.ring_pop) begin
                rslot_reg <= advance(rslot_reg, eff_cap);
                fill_reg  <= fill_reg - CW'(1);
            end else if (dcmd.ring_swap && fill_reg != '0) begin
                // slot refilled from the parked sender; buffer stays full
                rslot_reg <= advance(rslot_reg, eff_cap);
                wslot_reg <= advance(rslot_reg, eff_cap);
            end
            if (dcmd.rq_push) begin
                rtail_reg  <= rtail_reg + QW'(1);
                rcount_reg <= rcount_reg + CW'(1);
            end else if (dcmd.rq_pop) begin
                rhead_reg  <= rhead_reg + QW'(1);
                rcount_reg <= rcount_reg - CW'(1);
            end
            if (dcmd.sq_push) begin
                stail_reg  <= stail_reg + QW'(1);
                scount_reg <= scount_reg + CW'(1);
            end else if (dcmd.sq_pop) begin
                shead_reg  <= shead_reg + QW'(1);
                scount_reg <= scount_reg - CW'(1);
            end
        end
    end

    assign out_target = tgt_reg;
    assign out_status = st_reg;
    assign out_data   = od_reg;
    assign out_last   = last_reg;

    a_wait_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_sum <= (CW+1)'(PARK_LIMIT))
        else $error("wait queues exceed park limit");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(QUEUE_DEPTH))
        else $error("fill count above depth");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (dcmd.rq_pop || dcmd.sq_pop) |-> (rcount_reg != '0 || scount_reg != '0))
        else $error("pop from empty wait queue");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        dcmd.ring_push |=> fill_reg != '0)
        else $error("ring push lost");

endmodule
`default_nettype wire

[sv/bcw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcw_ctrl
// Command sequencer: decides each command's outcome and steps result transfers.
// ----------------------------------------------------------------------------
module bcw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire bcw_pkg::dp_stat_t dstat,
    output bcw_pkg::dp_cmd_t       dcmd
);
    import bcw_pkg::*;

    state_t state_reg, state_next;
    logic   blk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    function automatic res_t mk(input tsel_t t, input status_e s, input dsel_t d,
                                input logic l);
        res_t r;
        r.tsel = t; r.status = s; r.dsel = d; r.last = l;
        return r;
    endfunction

    always_comb begin
        state_next = state_reg;
        dcmd       = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        blk        = (dstat.cmd == CMD_SEND) || (dstat.cmd == CMD_RECV);
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dcmd.capture_in = 1'b1;
                    state_next      = S_RD;
                end
            end
            S_RD: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                dcmd.out_load = 1'b1;
                dcmd.out_res  = mk(TSEL_CALLER, ST_ERROR, DSEL_ZERO, 1'b1);
                state_next    = S_OUT_B;
                case (dstat.cmd)
                    CMD_SEND, CMD_TRY_SEND: begin
                        if (dstat.closed) begin
                            dcmd.out_res = mk(TSEL_CALLER, blk ? ST_ERROR : ST_CLOSED,
                                              DSEL_ZERO, 1'b1);
                        end else if (dstat.rq_nonempty) begin
                            dcmd.rq_pop    = 1'b1;
                            dcmd.out_res   = mk(TSEL_RECV, ST_OK, DSEL_IN, 1'b0);
                            dcmd.pend_load = 1'b1;
                            dcmd.pend_res  = mk(TSEL_CALLER, ST_OK, DSEL_ZERO, 1'b1);
                            state_next     = S_OUT_A;
                        end else if (dstat.has_room) begin
                            dcmd.ring_push = 1'b1;
                            dcmd.out_res   = mk(TSEL_CALLER, ST_OK, DSEL_ZERO, 1'b1);
                        end else if (!blk) begin
                            dcmd.out_res = mk(TSEL_CALLER, ST_BLOCK, DSEL_ZERO, 1'b1);
                        end else if (dstat.can_park_s) begin
                            dcmd.sq_push  = 1'b1;
                            dcmd.out_load = 1'b0;
                            state_next    = S_IDLE;
                        end
                    end
                    CMD_RECV, CMD_TRY_RECV: begin
                        if (dstat.closed && dstat.fill_zero) begin
                            dcmd.out_res = mk(TSEL_CALLER, ST_CLOSED, DSEL_ZERO, 1'b1);
                        end else if (dstat.sq_nonempty) begin
                            dcmd.sq_pop    = 1'b1;
                            dcmd.ring_swap = 1'b1;
                            dcmd.out_res   = mk(TSEL_SEND, ST_OK, DSEL_ZERO, 1'b0);
                            dcmd.pend_load = 1'b1;
                            dcmd.pend_res  = mk(TSEL_CALLER, ST_OK, DSEL_GOT, 1'b1);
                            state_next     = S_OUT_A;
                        end else if (!dstat.fill_zero) begin
                            dcmd.ring_pop = 1'b1;
                            dcmd.out_res  = mk(TSEL_CALLER, ST_OK, DSEL_RING, 1'b1);
                        end else if (!blk) begin
                            dcmd.out_res = mk(TSEL_CALLER, ST_BLOCK, DSEL_ZERO, 1'b1);
                        end else if (dstat.can_park_r) begin
                            dcmd.rq_push  = 1'b1;
                            dcmd.out_load = 1'b0;
                            state_next    = S_IDLE;
                        end
                    end
                    CMD_CLOSE: begin
                        if (!dstat.closed) begin
                            dcmd.set_closed = 1'b1;
                            dcmd.out_load   = 1'b0;
                            state_next      = S_CL_POP;
                        end
                    end
                    default: ;
                endcase
            end
            S_OUT_A: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    dcmd.out_load      = 1'b1;
                    dcmd.out_from_pend = 1'b1;
                    state_next         = S_OUT_B;
                end
            end
            S_OUT_B: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_CL_POP: begin
                // receivers drain first, then senders, then the caller's ack
                dcmd.out_load = 1'b1;
                if (dstat.rq_nonempty) begin
                    dcmd.rq_pop  = 1'b1;
                    dcmd.out_res = mk(TSEL_RECV, ST_CLOSED, DSEL_ZERO, 1'b0);
                    state_next   = S_CL_OUT;
                end else if (dstat.sq_nonempty) begin
                    dcmd.sq_pop  = 1'b1;
                    dcmd.out_res = mk(TSEL_SEND, ST_CLOSED, DSEL_ZERO, 1'b0);
                    state_next   = S_CL_OUT;
                end else begin
                    dcmd.out_res = mk(TSEL_CALLER, ST_OK, DSEL_ZERO, 1'b1);
                    state_next   = S_OUT_B;
                end
            end
            S_CL_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_CL_POP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_acc_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && s_valid) |=> state_reg == S_RD)
        else $error("accepted command not sequenced");
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT_A && m_ready) |=> state_reg == S_OUT_B)
        else $error("second result skipped");
    a_close_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CL_POP) |-> dstat.closed)
        else $error("drain while open");

endmodule
`default_nettype wire

[sv/bounded_channel_with_waiters.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_channel_with_waiters
// Buffered channel with ring buffer and FIFO queues of parked requesters.
// ----------------------------------------------------------------------------
// The command is captured in S_IDLE, memories are read in S_RD, and S_EXEC
// registers the first result; a second result follows as soon as the first
// is taken. A parking command returns to idle with no result; close answers
// every parked requester, receivers first, before the caller.
// The sequencer handles one command at a time; memory reads are registered.
// Reset (synchronous, aresetn low): channel open, buffer and queues empty,
// capacity 16.
module bounded_channel_with_waiters (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [3:0]  s_requester,
    input  wire logic [31:0] s_send_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_target,
    output logic [1:0]       m_status,
    output logic [31:0]      m_recv_data,
    output logic             m_last
);
    import bcw_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    bcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dstat   (dstat),
        .dcmd    (dcmd)
    );

    bcw_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (s_cmd),
        .in_who      (s_requester),
        .in_data     (s_send_data),
        .dcmd        (dcmd),
        .dstat       (dstat),
        .out_target  (m_target),
        .out_status  (m_status),
        .out_data    (m_recv_data),
        .out_last    (m_last)
    );

endmodule
`default_nettype wire

[tb/sv/bcw_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcw_scoreboard
// Watches the command and result channels of the channel block, predicts
// every answer from its own copy of buffer, wait queues and capacity, and
// compares each result transfer with the oldest predicted answer.
// ----------------------------------------------------------------------------
module bcw_scoreboard (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [3:0]  s_requester,
    input  wire logic [31:0] s_send_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [3:0]  m_target,
    input  wire logic [1:0]  m_status,
    input  wire logic [31:0] m_recv_data,
    input  wire logic        m_last,
    output int               errors,
    output int               outstanding,
    output logic [4:0]       buffered
);
    import bcw_pkg::*;

    typedef struct {
        logic [3:0]  target;
        status_e     status;
        logic [31:0] data;
        logic        last;
    } answer_t;

    answer_t answers_due[$];
    answer_t fresh[$];

    logic [4:0]  capacity;
    logic [31:0] ring [QUEUE_DEPTH];
    logic [3:0]  wr_slot, rd_slot;
    logic [4:0]  fill;
    logic        closed;
    logic [3:0]  rq_id [QUEUE_DEPTH];
    logic [3:0]  sq_id [QUEUE_DEPTH];
    logic [31:0] sq_data [QUEUE_DEPTH];
    logic [4:0]  rq_cnt, sq_cnt;
    logic [3:0]  rq_head, rq_tail, sq_head, sq_tail;

    initial begin
        errors = 0;
        outstanding = 0;
        buffered = '0;
    end

    function automatic logic [4:0] slots_in_use();
        return (capacity > QUEUE_DEPTH) ? 5'(QUEUE_DEPTH) : capacity;
    endfunction

    function automatic logic [3:0] next_slot(logic [3:0] s);
        logic [4:0] n;
        n = {1'b0, s} + 5'd1;
        return (n >= slots_in_use()) ? 4'd0 : n[3:0];
    endfunction

    function automatic bit room_to_park(logic [4:0] own);
        return own < QUEUE_DEPTH && (rq_cnt + sq_cnt) < PARK_LIMIT;
    endfunction

    task automatic answer(logic [3:0] who, status_e st, logic [31:0] d);
        answer_t a;
        a.target = who;
        a.status = st;
        a.data   = d;
        a.last   = 1'b0;
        fresh.push_back(a);
    endtask

    task automatic do_send(logic [3:0] who, logic [31:0] d, bit blocking);
        if (closed) begin
            answer(who, blocking ? ST_ERROR : ST_CLOSED, '0);
        end else if (rq_cnt > 0) begin
            answer(rq_id[rq_head], ST_OK, d);
            rq_head = rq_head + 4'd1;
            rq_cnt  = rq_cnt - 5'd1;
            answer(who, ST_OK, '0);
        end else if (fill < slots_in_use()) begin
            ring[wr_slot] = d;
            wr_slot = next_slot(wr_slot);
            fill = fill + 5'd1;
            answer(who, ST_OK, '0);
        end else if (!blocking) begin
            answer(who, ST_BLOCK, '0);
        end else if (room_to_park(sq_cnt)) begin
            sq_id[sq_tail]   = who;
            sq_data[sq_tail] = d;
            sq_tail = sq_tail + 4'd1;
            sq_cnt  = sq_cnt + 5'd1;
        end else begin
            answer(who, ST_ERROR, '0);
        end
    endtask

    task automatic do_recv(logic [3:0] who, bit blocking);
        logic [31:0] got;
        logic [3:0]  sender;
        if (closed && fill == 0) begin
            answer(who, ST_CLOSED, '0);
        end else if (sq_cnt > 0) begin
            sender = sq_id[sq_head];
            if (fill == 0) begin
                got = sq_data[sq_head];
            end else begin
                // full buffer: hand out the head, parked sender's item refills it
                got = ring[rd_slot];
                ring[rd_slot] = sq_data[sq_head];
                rd_slot = next_slot(rd_slot);
                wr_slot = rd_slot;
            end
            sq_head = sq_head + 4'd1;
            sq_cnt  = sq_cnt - 5'd1;
            answer(sender, ST_OK, '0);
            answer(who, ST_OK, got);
        end else if (fill > 0) begin
            got = ring[rd_slot];
            rd_slot = next_slot(rd_slot);
            fill = fill - 5'd1;
            answer(who, ST_OK, got);
        end else if (!blocking) begin
            answer(who, ST_BLOCK, '0);
        end else if (room_to_park(rq_cnt)) begin
            rq_id[rq_tail] = who;
            rq_tail = rq_tail + 4'd1;
            rq_cnt  = rq_cnt + 5'd1;
        end else begin
            answer(who, ST_ERROR, '0);
        end
    endtask

    task automatic do_close(logic [3:0] who);
        if (closed) begin
            answer(who, ST_ERROR, '0);
        end else begin
            closed = 1'b1;
            while (rq_cnt > 0) begin
                answer(rq_id[rq_head], ST_CLOSED, '0);
                rq_head = rq_head + 4'd1;
                rq_cnt  = rq_cnt - 5'd1;
            end
            while (sq_cnt > 0) begin
                answer(sq_id[sq_head], ST_CLOSED, '0);
                sq_head = sq_head + 4'd1;
                sq_cnt  = sq_cnt - 5'd1;
            end
            answer(who, ST_OK, '0);
        end
    endtask

    task automatic forecast(logic [2:0] cmd, logic [3:0] who, logic [31:0] d);
        fresh.delete();
        case (cmd)
            CMD_SEND:     do_send(who, d, 1'b1);
            CMD_TRY_SEND: do_send(who, d, 1'b0);
            CMD_RECV:     do_recv(who, 1'b1);
            CMD_TRY_RECV: do_recv(who, 1'b0);
            CMD_CLOSE:    do_close(who);
            default:      answer(who, ST_ERROR, '0);
        endcase
        if (fresh.size() > 0)
            fresh[fresh.size()-1].last = 1'b1;
        foreach (fresh[i])
            answers_due.push_back(fresh[i]);
    endtask

    task automatic compare(answer_t e);
        if (m_target !== e.target || m_status !== e.status ||
            m_recv_data !== e.data || m_last !== e.last) begin
            errors = errors + 1;
            $display("%0t: result differs: expected target %0d status %0d data %08h last %0d,",
                     $time, e.target, e.status, e.data, e.last);
            $display("%0t:   actual target %0d status %0d data %08h last %0d",
                     $time, m_target, m_status, m_recv_data, m_last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            capacity = 5'd16;
            wr_slot = '0; rd_slot = '0; fill = '0; closed = 1'b0;
            rq_cnt = '0; sq_cnt = '0;
            rq_head = '0; rq_tail = '0; sq_head = '0; sq_tail = '0;
            answers_due.delete();
        end else begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected result: expected none, actual target %0d status %0d data %08h",
                             $time, m_target, m_status, m_recv_data);
                end else begin
                    compare(answers_due.pop_front());
                end
            end
            if (s_valid && s_ready)
                forecast(s_cmd, s_requester, s_send_data);
        end
        outstanding = answers_due.size();
        buffered = fill;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives channel commands with random idle gaps and result back-pressure:
// directed rendezvous, parking and queue-limit cases, random traffic at
// several capacities, then close handling with the buffer loaded or drained.
// ----------------------------------------------------------------------------
module testbench;
    import bcw_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = '0;
    logic [3:0]  s_requester = '0;
    logic [31:0] s_send_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_target;
    logic [1:0]  m_status;
    logic [31:0] m_recv_data;
    logic        m_last;

    int          errors, outstanding;
    logic [4:0]  buffered;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    bounded_channel_with_waiters dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_requester(s_requester), .s_send_data(s_send_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_target(m_target),
        .m_status(m_status), .m_recv_data(m_recv_data), .m_last(m_last)
    );

    bcw_scoreboard sb (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_requester(s_requester), .s_send_data(s_send_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_target(m_target),
        .m_status(m_status), .m_recv_data(m_recv_data), .m_last(m_last),
        .errors(errors), .outstanding(outstanding), .buffered(buffered)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("bounded_channel_with_waiters: mismatch");
            $finish;
        end
    end

    // Leaves s_valid high after the transfer: the caller either issues the
    // next command in the same step or lowers it.
    task automatic issue(cmd_e cmd, logic [3:0] who, logic [31:0] d);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_requester <= who;
        s_send_data <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic issue_raw(logic [2:0] cmd, logic [3:0] who, logic [31:0] d);
        issue(cmd_e'(cmd), who, d);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        // a parking command may still be in flight
        repeat (8) @(posedge aclk);
    endtask

    // empties the buffer so a capacity change never exposes stale slots
    task automatic set_capacity(logic [4:0] v);
        settle();
        while (buffered != 0) begin
            issue(CMD_TRY_RECV, 4'($urandom), '0);
            settle();
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_traffic(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 30)      issue(CMD_SEND, 4'($urandom), $urandom);
            else if (r < 42) issue(CMD_TRY_SEND, 4'($urandom), $urandom);
            else if (r < 72) issue(CMD_RECV, 4'($urandom), $urandom);
            else if (r < 85) issue(CMD_TRY_RECV, 4'($urandom), $urandom);
            else if (r < 89) issue_raw(3'($urandom_range(5, 7)), 4'($urandom), $urandom);
            else             issue(CMD_SEND, 4'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // buffered path at reset capacity, data extremes
        issue(CMD_SEND, 4'd0, 32'h0000_0000);
        issue(CMD_SEND, 4'd15, 32'hFFFF_FFFF);
        issue(CMD_TRY_RECV, 4'd1, '0);
        issue(CMD_RECV, 4'd2, '0);
        issue(CMD_TRY_RECV, 4'd3, '0);
        issue(CMD_RECV, 4'd4, '0);
        issue(CMD_TRY_SEND, 4'd5, 32'hA5A5_5A5A);
        issue_raw(3'd5, 4'd6, '0);
        issue_raw(3'd6, 4'd7, '0);
        issue_raw(3'd7, 4'd8, 32'hFFFF_FFFF);

        // rendezvous: parked receivers up to the limit, then one too many
        set_capacity(5'd0);
        issue(CMD_TRY_SEND, 4'd9, 32'h1234_5678);
        issue(CMD_TRY_RECV, 4'd10, '0);
        for (int i = 0; i < 16; i++)
            issue(CMD_RECV, 4'(i), '0);
        for (int i = 0; i < 15; i++)
            issue(CMD_SEND, 4'(15 - i), $urandom);
        settle();
        // same for parked senders
        for (int i = 0; i < 16; i++)
            issue(CMD_SEND, 4'(i), $urandom);
        for (int i = 0; i < 15; i++)
            issue(CMD_RECV, 4'(i), '0);

        set_capacity(5'd1);
        random_traffic(15);
        set_capacity(5'd31);
        random_traffic(15);
        set_capacity(5'd3);
        random_traffic(15);
        set_capacity(5'd0);
        random_traffic(15);
        set_capacity(5'd16);
        random_traffic(15);

        // last part runs without idling; close with a loaded or a drained buffer
        quiet = 1'b1;
        set_capacity(5'd2);
        random_traffic(10);
        settle();
        if ($urandom_range(0, 1) == 0) begin
            while (buffered != 0) begin
                issue(CMD_TRY_RECV, 4'($urandom), '0);
                settle();
            end
            for (int i = 0; i < 4; i++)
                issue(CMD_RECV, 4'($urandom), '0);
        end else begin
            issue(CMD_TRY_SEND, 4'd1, $urandom);
            issue(CMD_TRY_SEND, 4'd2, $urandom);
            for (int i = 0; i < 4; i++)
                issue(CMD_SEND, 4'($urandom), $urandom);
        end
        issue(CMD_CLOSE, 4'd12, '0);
        issue(CMD_CLOSE, 4'd13, '0);
        issue(CMD_SEND, 4'd14, $urandom);
        issue(CMD_TRY_SEND, 4'd15, $urandom);
        for (int i = 0; i < 4; i++)
            issue(CMD_TRY_RECV, 4'($urandom), '0);
        issue(CMD_RECV, 4'd3, '0);
        issue_raw(3'd7, 4'd4, '0);

        settle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("bounded_channel_with_waiters: match");
        else
            $display("bounded_channel_with_waiters: mismatch");
        $finish;
    end

endmodule
